// File: rtl/morse_keying_encoder_defines.svh
// Assertion macros for the Morse keying encoder.
// Included by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef MORSE_KEYING_ENCODER_DEFINES_SVH
`define MORSE_KEYING_ENCODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MKE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define MKE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MKE_ASSERT_SAME(lbl, ante, cons, msg)
`define MKE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/mke_pkg.sv
// Shared types, code tables and lookup for the Morse keying encoder.
// No dependencies.
`timescale 1ns / 1ps
package mke_pkg;

   localparam int MAX_ELEMS = 5;
   localparam int LEN_W     = 3;

   // elems: first element at the MSB, 1 = dash
   typedef struct packed {
      logic             valid;
      logic [LEN_W-1:0] len;
      logic [MAX_ELEMS-1:0] elems;
   } code_type;

   typedef logic [LEN_W+MAX_ELEMS-1:0] entry_type;

   localparam entry_type LETTER_CODES [26] = '{
      {3'd2, 5'b01000}, {3'd4, 5'b10000}, {3'd4, 5'b10100}, {3'd3, 5'b10000},
      {3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b11000}, {3'd4, 5'b00000},
      {3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b10100}, {3'd4, 5'b01000},
      {3'd2, 5'b11000}, {3'd2, 5'b10000}, {3'd3, 5'b11100}, {3'd4, 5'b01100},
      {3'd4, 5'b11010}, {3'd3, 5'b01000}, {3'd3, 5'b00000}, {3'd1, 5'b10000},
      {3'd3, 5'b00100}, {3'd4, 5'b00010}, {3'd3, 5'b01100}, {3'd4, 5'b10010},
      {3'd4, 5'b10110}, {3'd4, 5'b11000}
   };

   localparam entry_type DIGIT_CODES [10] = '{
      {3'd5, 5'b11111}, {3'd5, 5'b01111}, {3'd5, 5'b00111}, {3'd5, 5'b00011},
      {3'd5, 5'b00001}, {3'd5, 5'b00000}, {3'd5, 5'b10000}, {3'd5, 5'b11000},
      {3'd5, 5'b11100}, {3'd5, 5'b11110}
   };

   localparam entry_type AR_CODE = {3'd5, 5'b01010};

   localparam logic [1:0] WORD_GAP_LAST = 2'd3;
   localparam logic [1:0] CHAR_GAP_LAST = 2'd1;
   localparam logic [1:0] DASH_EXTRA    = 2'd2;

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;

   function automatic code_type lookup_code(input logic [7:0] b);
      code_type   c;
      logic [7:0] idx;
      c   = '0;
      idx = '0;
      if (b inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
         idx = b - CH_UPPER_A;
         c   = {1'b1, LETTER_CODES[idx[4:0]]};
      end else if (b inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
         idx = b - CH_LOWER_A;
         c   = {1'b1, LETTER_CODES[idx[4:0]]};
      end else if (b inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
         idx = b - CH_DIGIT_0;
         c   = {1'b1, DIGIT_CODES[idx[3:0]]};
      end
      return c;
   endfunction

endpackage

// File: rtl/morse_keying_encoder.sv
// Top level of the Morse keying encoder: code lookup, element sequencer and output register.
// Depends on mke_pkg and morse_keying_encoder_defines.svh.
`timescale 1ns / 1ps
`include "morse_keying_encoder_defines.svh"
// One word in (a text byte or an end mark), one keying bit out per cycle while the result
// side takes it. The element sequencer emits at most one bit a cycle. A character keys
// 4 word-gap bits when a separator run lay between it and an earlier character, then 2
// bits per dot and 4 per dash, then 2 char-gap bits; 4 to 26 bits in all. A separator
// byte emits nothing. An end mark keys AR (16 bits) and clears the word-gap state. The
// input is ready only while the sequencer is idle; the last bit of a character may still
// sit in the output register then.
module morse_keying_encoder
   import mke_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_key_bit,
   output logic       rsp_run_last,
   output logic       rsp_message_done
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_GAP   = 3'd1;
   localparam logic [2:0] ST_MARK  = 3'd2;
   localparam logic [2:0] ST_SPACE = 3'd3;
   localparam logic [2:0] ST_TAIL  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic [MAX_ELEMS-1:0] elems_ff, elems_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 eot_ff, eot_in;
   logic                 seen_ff, seen_in;
   logic                 pend_ff, pend_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_key_ff, out_key_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_done_ff, out_done_in;

   code_type  code;
   entry_type ld;
   logic      accept;
   logic      adv;
   logic      emit;
   logic      emit_bit;
   logic      emit_last;

   assign accept = req_valid && req_ready;
   assign adv    = !out_valid_ff || rsp_ready;
   assign code   = lookup_code(req_text_byte);
   assign ld     = req_end_of_text ? AR_CODE : {code.len, code.elems};

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      elems_in  = elems_ff;
      len_in    = len_ff;
      eot_in    = eot_ff;
      seen_in   = seen_ff;
      pend_in   = pend_ff;
      emit      = 1'b0;
      emit_bit  = 1'b0;
      emit_last = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_end_of_text || code.valid) begin
                  len_in   = ld[LEN_W+MAX_ELEMS-1:MAX_ELEMS];
                  elems_in = ld[MAX_ELEMS-1:0];
                  eot_in   = req_end_of_text;
                  if (!req_end_of_text && seen_ff && pend_ff) begin
                     state_in = ST_GAP;
                     cnt_in   = WORD_GAP_LAST;
                  end else begin
                     state_in = ST_MARK;
                     cnt_in   = ld[MAX_ELEMS-1] ? DASH_EXTRA : 2'd0;
                  end
                  seen_in = !req_end_of_text;
                  pend_in = 1'b0;
               end else if (seen_ff) begin
                  pend_in = 1'b1;
               end
            end
         end
         ST_GAP: begin
            if (adv) begin
               emit = 1'b1;
               if (cnt_ff == 2'd0) begin
                  state_in = ST_MARK;
                  cnt_in   = elems_ff[MAX_ELEMS-1] ? DASH_EXTRA : 2'd0;
               end else begin
                  cnt_in = cnt_ff - 2'd1;
               end
            end
         end
         ST_MARK: begin
            if (adv) begin
               emit     = 1'b1;
               emit_bit = 1'b1;
               if (cnt_ff == 2'd0) begin
                  state_in = ST_SPACE;
               end else begin
                  cnt_in = cnt_ff - 2'd1;
               end
            end
         end
         ST_SPACE: begin
            if (adv) begin
               emit = 1'b1;
               if (len_ff == LEN_W'(1)) begin
                  state_in = ST_TAIL;
                  cnt_in   = CHAR_GAP_LAST;
               end else begin
                  state_in = ST_MARK;
                  elems_in = {elems_ff[MAX_ELEMS-2:0], 1'b0};
                  len_in   = len_ff - LEN_W'(1);
                  cnt_in   = elems_ff[MAX_ELEMS-2] ? DASH_EXTRA : 2'd0;
               end
            end
         end
         ST_TAIL: begin
            if (adv) begin
               emit = 1'b1;
               if (cnt_ff == 2'd0) begin
                  emit_last = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff - 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_key_in   = out_key_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_key_in   = emit_bit;
         out_last_in  = emit_last;
         out_done_in  = emit_last && eot_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      elems_ff    <= elems_in;
      len_ff      <= len_in;
      eot_ff      <= eot_in;
      out_key_ff  <= out_key_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = out_valid_ff;
   assign rsp_key_bit      = out_key_ff;
   assign rsp_run_last     = out_last_ff;
   assign rsp_message_done = out_done_ff;

   `MKE_ASSERT_NEXT(a_eot_no_gap, accept && req_end_of_text, state_ff == ST_MARK, "gap before AR")
   `MKE_ASSERT_SAME(a_gap_needs_seen, state_ff == ST_GAP, seen_ff, "word gap without a character")
   `MKE_ASSERT_SAME(a_done_is_last, rsp_valid && rsp_message_done, rsp_run_last, "done not last")
   `MKE_ASSERT_SAME(a_mark_not_last, rsp_valid && rsp_key_bit, !rsp_run_last, "word ends on tone")

endmodule
